// ===== design/clns_pkg.sv =====
// Shared types, constants and the microprogram for the character-LCD nibble serializer.
// No dependencies; every other design file imports this package.
package clns_pkg;

  typedef enum logic [1:0] {
    MODE_DATA = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_GOTO = 2'd2,
    MODE_NUM  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
    logic [1:0]  row;
    logic [5:0]  col;
  } in_word_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } out_word_t;

  localparam logic [7:0]  CFG_BASE_RST = 8'h80;
  localparam logic [31:0] DIV10_RECIP  = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT  = 35;
  localparam logic [3:0]  ASCII_HI     = 4'h3;

  // Datapath operations, one per microprogram step
  typedef enum logic [2:0] {
    OP_LATCH,
    OP_LOAD_BYTE,
    OP_EMIT_HI,
    OP_EMIT_LO,
    OP_MUL,
    OP_REM,
    OP_POP
  } dp_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_GO,
    JMP_IF,
    JMP_IF_HOME
  } jmp_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NUM,
    COND_MORE,
    COND_DIGITS
  } cond_e;

  localparam int PC_W = 3;

  localparam logic [PC_W-1:0] STEP_IDLE    = 3'd0;
  localparam logic [PC_W-1:0] STEP_LOAD    = 3'd1;
  localparam logic [PC_W-1:0] STEP_EMIT_HI = 3'd2;
  localparam logic [PC_W-1:0] STEP_EMIT_LO = 3'd3;
  localparam logic [PC_W-1:0] STEP_MUL     = 3'd4;
  localparam logic [PC_W-1:0] STEP_REM     = 3'd5;
  localparam logic [PC_W-1:0] STEP_POP     = 3'd6;

  typedef struct packed {
    logic            accept;
    logic            wait_out;
    dp_op_e          op;
    jmp_e            jmp;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } cw_t;

  // Sequencer to datapath
  typedef struct packed {
    dp_op_e op;
    logic   go;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic is_num;
    logic more;
    logic digits_left;
    logic out_free;
  } status_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      2'd3:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Microprogram ROM
  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t w;
    case (pc)
      STEP_IDLE:    w = '{1'b1, 1'b0, OP_LATCH,     JMP_IF,      COND_NUM,    STEP_MUL};
      STEP_LOAD:    w = '{1'b0, 1'b0, OP_LOAD_BYTE, JMP_NEXT,    COND_NONE,   STEP_IDLE};
      STEP_EMIT_HI: w = '{1'b0, 1'b1, OP_EMIT_HI,   JMP_NEXT,    COND_NONE,   STEP_IDLE};
      STEP_EMIT_LO: w = '{1'b0, 1'b1, OP_EMIT_LO,   JMP_IF_HOME, COND_DIGITS, STEP_POP};
      STEP_MUL:     w = '{1'b0, 1'b0, OP_MUL,       JMP_NEXT,    COND_NONE,   STEP_IDLE};
      STEP_REM:     w = '{1'b0, 1'b0, OP_REM,       JMP_IF,      COND_MORE,   STEP_MUL};
      STEP_POP:     w = '{1'b0, 1'b0, OP_POP,       JMP_GO,      COND_NONE,   STEP_EMIT_HI};
      default:      w = '{1'b0, 1'b0, OP_LATCH,     JMP_GO,      COND_NONE,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/char_lcd_nibble_serializer.sv =====
// Character-LCD 4-bit bus serializer: takes one LCD request per input word and sends
// it as register-select plus nibble words, high nibble first. A data, command or
// go-to-row/column request runs the latch, load and two nibble steps; a decimal number
// with d digits runs one latch step, and each digit costs one multiply step and one
// remainder step of the reciprocal divide-by-ten unit, then one pop and two nibble
// steps. Output stalls hold the nibble steps, since the single output register must
// empty before the next nibble step advances. Numbers with more than MAX_DIGITS digits
// send only their MAX_DIGITS low digits. The DDRAM command base is written through
// the cfg port, which is always ready; write it only while the block is idle.
module char_lcd_nibble_serializer import clns_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] base_q;
  ctrl_t      ctrl;
  status_t    status;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= CFG_BASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !accept;

  clns_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .accept_o (accept)
  );

  clns_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .base_i      (base_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .status_o    (status)
  );

endmodule

// ===== design/clns_seq.sv =====
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on clns_pkg.
module clns_seq import clns_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    accept_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  cw_t             cw;
  logic            hold;
  logic            cond_val;
  logic [PC_W-1:0] pc_inc;

  assign cw     = ucode(pc_q);
  assign pc_inc = pc_q + 1'b1;

  // Hold the step while waiting for an input word or for room at the output
  assign hold = (cw.accept && !status_i.in_valid) || (cw.wait_out && !status_i.out_free);

  always_comb begin
    case (cw.cond)
      COND_NUM:    cond_val = status_i.is_num;
      COND_MORE:   cond_val = status_i.more;
      COND_DIGITS: cond_val = status_i.digits_left;
      default:     cond_val = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_d = pc_q;
    end else begin
      case (cw.jmp)
        JMP_GO:      pc_d = cw.target;
        JMP_IF:      pc_d = cond_val ? cw.target : pc_inc;
        JMP_IF_HOME: pc_d = cond_val ? cw.target : STEP_IDLE;
        default:     pc_d = pc_inc;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op = cw.op;
  assign ctrl_o.go = !hold;
  assign accept_o  = cw.accept;

endmodule

// ===== design/clns_datapath.sv =====
// Datapath: request registers, divide-by-ten unit, digit stack and output register.
// Depends on clns_pkg; driven step by step by clns_seq.
module clns_datapath import clns_pkg::*; #(
  parameter int MAX_DIGITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  logic       in_valid_i,
  input  in_word_t   in_word_i,
  input  logic [7:0] base_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_word_t  out_word_o,
  output status_t    status_o
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int QUO_W = 64 - DIV10_SHIFT;

  logic [1:0]       mode_q;
  logic [31:0]      rest_q;
  logic [1:0]       row_q;
  logic [5:0]       col_q;
  logic [7:0]       byte_q;
  logic             rs_q;
  logic [63:0]      prod_q;
  logic [3:0]       dig_q [MAX_DIGITS];
  logic [CNT_W-1:0] n_q;
  logic             out_valid_q;
  out_word_t        out_word_q;

  logic [QUO_W-1:0] quot;
  logic [31:0]      quot_x10;
  logic [31:0]      rem_full;
  logic [CNT_W-1:0] n_dec;
  logic [7:0]       goto_addr;
  logic             out_free;
  logic             emit;

  assign quot      = prod_q[63:DIV10_SHIFT];
  assign quot_x10  = (32'(quot) << 3) + (32'(quot) << 1);
  assign rem_full  = rest_q - quot_x10;
  assign n_dec     = n_q - 1'b1;
  assign goto_addr = row_base(row_q) + {2'b00, col_q} + base_i;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = ctrl_i.go && (ctrl_i.op == OP_EMIT_HI || ctrl_i.op == OP_EMIT_LO);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.go) begin
        case (ctrl_i.op)
          OP_LATCH: n_q <= '0;
          OP_REM:   n_q <= n_q + 1'b1;
          OP_POP:   n_q <= n_dec;
          default:  n_q <= n_q;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.go) begin
      case (ctrl_i.op)
        OP_LATCH: begin
          mode_q <= in_word_i.mode;
          rest_q <= in_word_i.value;
          row_q  <= in_word_i.row;
          col_q  <= in_word_i.col;
        end
        OP_LOAD_BYTE: begin
          byte_q <= (mode_q == MODE_GOTO) ? goto_addr : rest_q[7:0];
          rs_q   <= (mode_q == MODE_DATA);
        end
        OP_MUL: begin
          prod_q <= 64'(rest_q) * 64'(DIV10_RECIP);
        end
        OP_REM: begin
          dig_q[n_q[IDX_W-1:0]] <= rem_full[3:0];
          rest_q <= 32'(quot);
        end
        OP_POP: begin
          byte_q <= {ASCII_HI, dig_q[n_dec[IDX_W-1:0]]};
          rs_q   <= 1'b1;
        end
        OP_EMIT_HI: begin
          out_word_q <= '{reg_select: rs_q, nibble: byte_q[7:4], last: 1'b0};
        end
        OP_EMIT_LO: begin
          out_word_q <= '{reg_select: rs_q, nibble: byte_q[3:0], last: (n_q == '0)};
        end
        default: begin
          rs_q <= rs_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign status_o.in_valid    = in_valid_i;
  assign status_o.is_num      = (in_word_i.mode == MODE_NUM);
  // Keep dividing while digits remain and the stack has room
  assign status_o.more        = (quot != '0) && (n_q != CNT_W'(MAX_DIGITS - 1));
  assign status_o.digits_left = (n_q != '0);
  assign status_o.out_free    = out_free;

endmodule

// ===== design/clns_checker.sv =====
// Port-level checks for the character-LCD nibble serializer, bound to the top level.
// Depends on clns_pkg.
module clns_checker import clns_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // An accepted request is never followed directly by a second accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // No new request while a sequence is still mid-way
  a_no_accept_mid_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_word_o.last |-> in_stall_o)
    else $error("input open before the last word was sent");

  // While open for input, any pending output word closes its sequence
  a_idle_pending_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && out_valid_o |-> out_word_o.last)
    else $error("open for input with a non-final word pending");

endmodule

bind char_lcd_nibble_serializer clns_checker u_chk (.*);
